@@ src/bsb_pkg.sv @@
// ----------------------------------------------------------------------------
// bsb_pkg
// Shared types and constants of the B-spline basis evaluator.
// ----------------------------------------------------------------------------
package bsb_pkg;

  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_EVAL  = 1'b1;

  localparam logic [16:0] ONE_Q16     = 17'd65536;
  localparam logic [15:0] ONE_Q12     = 16'd4096;
  localparam logic [3:0]  ORDER_RESET = 4'd4;

  typedef struct packed {
    logic        func;
    logic [4:0]  index;
    logic [15:0] value;
  } bsb_in_t;

  typedef struct packed {
    logic [16:0] basis_value;
    logic        range_error;
  } bsb_out_t;

  typedef enum logic [7:0] {
    ST_IDLE = 8'b0000_0001,
    ST_STEP = 8'b0000_0010,
    ST_READ = 8'b0000_0100,
    ST_DIV1 = 8'b0000_1000,
    ST_DIV2 = 8'b0001_0000,
    ST_MUL  = 8'b0010_0000,
    ST_SUM  = 8'b0100_0000,
    ST_FIN  = 8'b1000_0000
  } bsb_state_t;

endpackage

@@ src/bsb_knot_ram.sv @@
// ----------------------------------------------------------------------------
// bsb_knot_ram
// Knot store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module bsb_knot_ram #(
  parameter int DEPTH = 32,
  parameter int AW    = 5
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [15:0]   wdata,
  input  logic [AW-1:0] raddr,
  output logic [15:0]   rdata
);

  logic [15:0] mem_r [DEPTH];
  logic [15:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

@@ src/bsb_div.sv @@
// ----------------------------------------------------------------------------
// bsb_div
// Unsigned restoring divider, 32-bit dividend by 16-bit divisor, one bit a cycle.
// ----------------------------------------------------------------------------
module bsb_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [15:0] divisor,
  output logic        busy,
  output logic        done,
  output logic [31:0] quotient
);

  logic [4:0]  cnt_r,  cnt_nxt;
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [15:0] rem_r,  rem_nxt;
  logic [31:0] quo_r,  quo_nxt;
  logic [15:0] dvs_r,  dvs_nxt;
  logic [16:0] shifted;
  logic        fits;

  assign shifted = {rem_r, quo_r[31]};
  assign fits    = shifted >= {1'b0, dvs_r};

  always_comb begin
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    if (start && !busy_r) begin
      cnt_nxt  = 5'd31;
      busy_nxt = 1'b1;
      rem_nxt  = 16'd0;
      quo_nxt  = dividend;
      dvs_nxt  = divisor;
    end else if (busy_r) begin
      rem_nxt = fits ? 16'(shifted - {1'b0, dvs_r}) : shifted[15:0];
      quo_nxt = {quo_r[30:0], fits};
      cnt_nxt = cnt_r - 5'd1;
      if (cnt_r == 5'd0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    cnt_r <= cnt_nxt;
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
  end

  assign busy     = busy_r;
  assign done     = done_r;
  assign quotient = quo_r;

endmodule

@@ src/bspline_basis_eval.sv @@
// ----------------------------------------------------------------------------
// bspline_basis_eval
// Cox-de Boor B-spline basis evaluator over a stored knot vector.
//
// Requests enter on in_data when start is high and busy is low. A write
// request (func 0) stores one knot in the knot RAM and gives no result. An
// evaluate request (func 1) gives one result on out_data, marked by a
// one-cycle out_valid strobe; the receiver cannot stall and must take it.
// The order register is written on the cfg channel (cfg_valid/cfg_ready)
// while the block is idle.
// An out-of-range evaluate answers in the next cycle with range_error set.
// Otherwise the block steps through a triangle of order levels, each level
// MAX_ORDER+1 slots. An active term takes a step, knot reads from the RAM's
// single read port, two divisions on the shared divider, a multiply and a
// sum. An active order-one slot takes a step and the knot reads, and an
// idle slot only a step. The next request is taken in the cycle of the
// result strobe.
// Reset clears the sequencer, the result strobe and sets the order to 4;
// the knot RAM holds no defined contents until written.
// ----------------------------------------------------------------------------
module bspline_basis_eval #(
  parameter int KNOT_SLOTS = 32,
  parameter int MAX_ORDER  = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  bsb_pkg::bsb_in_t in_data,
  output logic             out_valid,
  output bsb_pkg::bsb_out_t out_data,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [3:0]       cfg_data
);

  localparam int AW = (KNOT_SLOTS > 1) ? $clog2(KNOT_SLOTS) : 1;
  localparam int LV = MAX_ORDER + 1;
  localparam int JW = $clog2(LV);
  localparam int MW = $clog2(MAX_ORDER + 1);
  localparam int EW = 10;

  bsb_pkg::bsb_state_t state_r, state_nxt;
  logic [3:0]    order_r;
  logic [MW-1:0] k_r, m_r;
  logic [JW-1:0] j_r;
  logic [4:0]    idx_r;
  logic [15:0]   u_r;
  logic [2:0]    rcnt_r;
  logic [15:0]   t_r [4];
  logic          neg1_r, neg2_r;
  logic [31:0]   q1_r;
  logic [32:0]   p1_r, p2_r;
  logic [16:0]   lv_r [LV];
  logic          out_valid_r;
  bsb_pkg::bsb_out_t out_r;

  logic          accept;
  logic [EW-1:0] kc, base, addr_ext, active_sum;
  logic          range_bad, active, last_slot;
  logic [16:0]   newv;
  logic          advance;

  logic          ram_we;
  logic [15:0]   ram_rdata;

  logic          div_start, div_busy, div_done, div_sel1;
  logic [31:0]   div_q;
  logic [16:0]   n17, d17;
  logic          dz;
  logic [15:0]   nmag, dmag;
  logic          neg_cur;

  logic [48:0]   prod1, prod2;
  logic [34:0]   term1, term2, ssum;

  assign accept    = start && !busy;
  assign busy      = (state_r != bsb_pkg::ST_IDLE);
  assign cfg_ready = (state_r == bsb_pkg::ST_IDLE);

  always_comb begin
    if (order_r == 4'd0) begin
      kc = EW'(1);
    end else if (EW'(order_r) > EW'(MAX_ORDER)) begin
      kc = EW'(MAX_ORDER);
    end else begin
      kc = EW'(order_r);
    end
  end

  assign range_bad  = (EW'(in_data.index) + kc) > EW'(KNOT_SLOTS - 1);
  assign base       = EW'(idx_r) + EW'(j_r);
  assign active_sum = EW'(j_r) + EW'(m_r);
  assign active     = active_sum <= EW'(k_r);
  assign last_slot  = (j_r == JW'(LV - 1));

  always_comb begin
    case (rcnt_r)
      3'd0:    addr_ext = base;
      3'd1:    addr_ext = base + EW'(1);
      3'd2:    addr_ext = base + EW'(m_r) - EW'(1);
      default: addr_ext = base + EW'(m_r);
    endcase
  end

  assign ram_we = accept && (in_data.func == bsb_pkg::FUNC_WRITE)
                  && (EW'(in_data.index) < EW'(KNOT_SLOTS));

  bsb_knot_ram #(.DEPTH(KNOT_SLOTS), .AW(AW)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (in_data.index[AW-1:0]),
    .wdata (in_data.value),
    .raddr (addr_ext[AW-1:0]),
    .rdata (ram_rdata)
  );

  assign div_sel1 = (state_r == bsb_pkg::ST_READ);
  assign n17 = div_sel1 ? ({1'b0, u_r} - {1'b0, t_r[0]}) : ({1'b0, t_r[3]} - {1'b0, u_r});
  assign d17 = div_sel1 ? ({1'b0, t_r[2]} - {1'b0, t_r[0]})
                        : ({1'b0, t_r[3]} - {1'b0, t_r[1]});
  assign dz      = (d17 == 17'd0);
  assign nmag    = n17[16] ? 16'(-n17) : n17[15:0];
  assign dmag    = dz ? bsb_pkg::ONE_Q12 : (d17[16] ? 16'(-d17) : d17[15:0]);
  assign neg_cur = n17[16] ^ (d17[16] && !dz);

  assign div_start = ((state_r == bsb_pkg::ST_READ) && (rcnt_r == 3'd5) && (m_r != MW'(1)))
                     || ((state_r == bsb_pkg::ST_DIV1) && div_done);

  bsb_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend ({nmag, 16'd0}),
    .divisor  (dmag),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_q)
  );

  assign prod1 = 49'(q1_r) * 49'(lv_r[0]);
  assign prod2 = 49'(div_q) * 49'(lv_r[1]);
  assign term1 = neg1_r ? 35'(-{2'b00, p1_r}) : {2'b00, p1_r};
  assign term2 = neg2_r ? 35'(-{2'b00, p2_r}) : {2'b00, p2_r};
  assign ssum  = term1 + term2;

  always_comb begin
    state_nxt = state_r;
    advance   = 1'b0;
    newv      = 17'd0;
    case (state_r)
      bsb_pkg::ST_IDLE: begin
        if (accept && (in_data.func == bsb_pkg::FUNC_EVAL) && !range_bad) begin
          state_nxt = bsb_pkg::ST_STEP;
        end
      end
      bsb_pkg::ST_STEP: begin
        if (active) begin
          state_nxt = bsb_pkg::ST_READ;
        end else begin
          newv    = (m_r == MW'(1)) ? 17'd0 : lv_r[0];
          advance = 1'b1;
        end
      end
      bsb_pkg::ST_READ: begin
        if (rcnt_r == 3'd5) begin
          if (m_r == MW'(1)) begin
            newv    = ((u_r >= t_r[0]) && (u_r < t_r[1])) ? bsb_pkg::ONE_Q16 : 17'd0;
            advance = 1'b1;
          end else begin
            state_nxt = bsb_pkg::ST_DIV1;
          end
        end
      end
      bsb_pkg::ST_DIV1: begin
        if (div_done) begin
          state_nxt = bsb_pkg::ST_DIV2;
        end
      end
      bsb_pkg::ST_DIV2: begin
        if (div_done) begin
          state_nxt = bsb_pkg::ST_MUL;
        end
      end
      bsb_pkg::ST_MUL: begin
        state_nxt = bsb_pkg::ST_SUM;
      end
      bsb_pkg::ST_SUM: begin
        if (ssum[34]) begin
          newv = 17'd0;
        end else if (ssum > 35'(bsb_pkg::ONE_Q16)) begin
          newv = bsb_pkg::ONE_Q16;
        end else begin
          newv = ssum[16:0];
        end
        advance = 1'b1;
      end
      bsb_pkg::ST_FIN: begin
        state_nxt = bsb_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = bsb_pkg::ST_IDLE;
      end
    endcase
    if (advance) begin
      if (last_slot && (m_r == k_r)) begin
        state_nxt = bsb_pkg::ST_FIN;
      end else begin
        state_nxt = bsb_pkg::ST_STEP;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bsb_pkg::ST_IDLE;
      order_r     <= bsb_pkg::ORDER_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        order_r <= cfg_data;
      end
      if (accept && (in_data.func == bsb_pkg::FUNC_EVAL) && range_bad) begin
        out_valid_r <= 1'b1;
      end
      if (state_r == bsb_pkg::ST_FIN) begin
        out_valid_r <= 1'b1;
      end
    end

    if (accept) begin
      idx_r <= in_data.index;
      u_r   <= in_data.value;
      k_r   <= MW'(kc);
      m_r   <= MW'(1);
      j_r   <= '0;
      out_r.basis_value <= 17'd0;
      out_r.range_error <= 1'b1;
    end
    if (state_r == bsb_pkg::ST_FIN) begin
      out_r.basis_value <= lv_r[0];
      out_r.range_error <= 1'b0;
    end

    if (state_r == bsb_pkg::ST_READ) begin
      rcnt_r <= rcnt_r + 3'd1;
      if (rcnt_r != 3'd0 && rcnt_r != 3'd5) begin
        t_r[rcnt_r[1:0] - 2'd1] <= ram_rdata;
      end
    end else begin
      rcnt_r <= 3'd0;
    end

    if (div_start) begin
      if (div_sel1) begin
        neg1_r <= neg_cur;
      end else begin
        neg2_r <= neg_cur;
      end
    end
    if ((state_r == bsb_pkg::ST_DIV1) && div_done) begin
      q1_r <= div_q;
    end
    if (state_r == bsb_pkg::ST_MUL) begin
      p1_r <= prod1[48:16];
      p2_r <= prod2[48:16];
    end

    if (advance) begin
      for (int i = 0; i < LV - 1; i++) begin
        lv_r[i] <= lv_r[i+1];
      end
      lv_r[LV-1] <= newv;
      if (last_slot) begin
        j_r <= '0;
        m_r <= m_r + MW'(1);
      end else begin
        j_r <= j_r + JW'(1);
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

`ifndef SYNTHESIS
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.range_error) |-> (out_data.basis_value == 17'd0))
    else $error("range error result carries a nonzero value");

  a_val_unit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.basis_value <= bsb_pkg::ONE_Q16))
    else $error("basis value above one");

  a_mul_order: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == bsb_pkg::ST_MUL) |-> (m_r > MW'(1)))
    else $error("multiply step at order one");

  a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == bsb_pkg::ST_IDLE) |-> !div_busy)
    else $error("divider running while idle");
`endif

endmodule

@@ tb/sv/bsb_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsb_checker
// Watches the request, result and order channels of the B-spline basis
// evaluator. It keeps its own knot vector and order, computes the
// Cox-de Boor value of every evaluate request, and compares each result
// strobe with the oldest pending value.
// ----------------------------------------------------------------------------
module bsb_checker (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic              busy,
  input  bsb_pkg::bsb_in_t  in_data,
  input  logic              out_valid,
  input  bsb_pkg::bsb_out_t out_data,
  input  logic              cfg_valid,
  input  logic              cfg_ready,
  input  logic [3:0]        cfg_data,
  output int                pending,
  output int                errors
);

  logic [15:0] knots [0:31];
  logic [3:0]  order_q;
  bsb_pkg::bsb_out_t basis_q [$];

  function automatic bsb_pkg::bsb_out_t eval_basis(input logic [4:0] idx,
                                                   input logic [15:0] u);
    bsb_pkg::bsb_out_t r;
    longint   lvl [0:8];
    longint   ta, ta1, tam1, tam, d1, d2, r1, r2, s;
    int       k, m, j, a;
    k = order_q;
    if (k < 1) k = 1;
    if (k > 8) k = 8;
    r.basis_value = '0;
    r.range_error = 1'b0;
    if (int'(idx) + k > 31) begin
      r.range_error = 1'b1;
      return r;
    end
    for (j = 0; j < k; j++) begin
      lvl[j] = (u >= knots[idx + j] && u < knots[idx + j + 1]) ? 65536 : 0;
    end
    for (m = 2; m <= k; m++) begin
      for (j = 0; j + m <= k; j++) begin
        a    = idx + j;
        ta   = knots[a];
        ta1  = knots[a + 1];
        tam1 = knots[a + m - 1];
        tam  = knots[a + m];
        d1   = tam1 - ta;
        d2   = tam - ta1;
        if (d1 == 0) d1 = bsb_pkg::ONE_Q12;
        if (d2 == 0) d2 = bsb_pkg::ONE_Q12;
        r1 = ((longint'(u) - ta) * 65536) / d1;
        r2 = ((tam - longint'(u)) * 65536) / d2;
        s  = (r1 * lvl[j]) / 65536 + (r2 * lvl[j + 1]) / 65536;
        if (s < 0) s = 0;
        if (s > 65536) s = 65536;
        lvl[j] = s;
      end
    end
    r.basis_value = lvl[0][16:0];
    return r;
  endfunction

  assign pending = basis_q.size();

  always @(posedge clk) begin
    bsb_pkg::bsb_out_t exp_r;
    if (!rst_n) begin
      order_q <= bsb_pkg::ORDER_RESET;
      basis_q.delete();
      errors  <= 0;
    end else begin
      if (out_valid) begin
        if (basis_q.size() == 0) begin
          $display("%0t: unexpected result, actual value %0d error %0b", $time,
                   out_data.basis_value, out_data.range_error);
          errors <= errors + 1;
        end else begin
          exp_r = basis_q.pop_front();
          if (out_data.basis_value !== exp_r.basis_value ||
              out_data.range_error !== exp_r.range_error) begin
            $display("%0t: mismatch, expected value %0d error %0b, actual value %0d error %0b",
                     $time, exp_r.basis_value, exp_r.range_error,
                     out_data.basis_value, out_data.range_error);
            errors <= errors + 1;
          end
        end
      end
      if (start && !busy) begin
        if (in_data.func == bsb_pkg::FUNC_WRITE) knots[in_data.index] = in_data.value;
        else basis_q.push_back(eval_basis(in_data.index, in_data.value));
      end
      if (cfg_valid && cfg_ready) order_q <= cfg_data;
    end
  end

endmodule

@@ tb/sv/tb_bspline_basis_eval.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_bspline_basis_eval
// Drives knot writes and basis evaluations into the B-spline evaluator over
// a sweep of order settings, with random gaps, and reports the verdict from
// the checker's failure and pending counts.
// ----------------------------------------------------------------------------
module tb_bspline_basis_eval;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       start = 1'b0;
  logic       busy;
  bsb_pkg::bsb_in_t  in_data = '0;
  logic       out_valid;
  bsb_pkg::bsb_out_t out_data;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [3:0] cfg_data = '0;
  int         pending;
  int         errors;

  logic [15:0] shadow_knots [0:31];
  int          eff_order;

  bspline_basis_eval u_top (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_data(in_data),
    .out_valid(out_valid), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  bsb_checker u_checker (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_data(in_data),
    .out_valid(out_valid), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .pending(pending), .errors(errors)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  initial begin
    #20ms;
    $display("bspline_basis_eval test failed");
    $finish;
  end

  // hold the request until taken
  task automatic issue(input logic f, input logic [4:0] idx, input logic [15:0] v);
    bsb_pkg::bsb_in_t r;
    r.func  = f;
    r.index = idx;
    r.value = v;
    start   <= 1'b1;
    in_data <= r;
    if (f == bsb_pkg::FUNC_WRITE) shadow_knots[idx] = v;
    do @(negedge clk); while (busy);
    @(posedge clk);
  endtask

  task automatic gap(input int n);
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    do @(negedge clk); while (pending != 0 || busy);
    repeat (20) @(posedge clk);
  endtask

  task automatic set_order(input logic [3:0] k);
    cfg_valid <= 1'b1;
    cfg_data  <= k;
    do @(negedge clk); while (!cfg_ready);
    @(posedge clk);
    cfg_valid <= 1'b0;
    eff_order = (k == 0) ? 1 : (k > 8) ? 8 : int'(k);
  endtask

  task automatic load_knots(input bit disordered);
    int          acc;
    logic [15:0] v;
    acc = $urandom_range(0, 2000);
    for (int s = 0; s < 32; s++) begin
      if (disordered) v = 16'($urandom_range(0, 65535));
      else begin
        if ($urandom_range(0, 99) >= 20) acc += $urandom_range(1, 2500);
        v = (acc > 65535) ? 16'hFFFF : acc[15:0];
      end
      issue(bsb_pkg::FUNC_WRITE, s[4:0], v);
    end
  endtask

  initial begin
    logic [3:0]  orders [10] = '{4'd1, 4'd8, 4'd2, 4'd0, 4'd3, 4'd15, 4'd5, 4'd4, 4'd6, 4'd7};
    logic [15:0] dir_knots [9] = '{16'd0, 16'd0, 16'd4096, 16'd8192, 16'd8192,
                                   16'd12288, 16'd16384, 16'hFFFF, 16'hFFFF};
    int          idx, lo, hi, no_idle;
    eff_order = 4;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: zero spans, top knots, range errors at reset order
    for (int s = 0; s < 9; s++) issue(bsb_pkg::FUNC_WRITE, s[4:0], dir_knots[s]);
    for (int s = 27; s < 31; s++) issue(bsb_pkg::FUNC_WRITE, s[4:0], 16'hFFFF);
    issue(bsb_pkg::FUNC_WRITE, 5'd31, 16'hFFFF);
    issue(bsb_pkg::FUNC_WRITE, 5'd31, 16'd0);
    issue(bsb_pkg::FUNC_EVAL, 5'd0, 16'd0);
    issue(bsb_pkg::FUNC_EVAL, 5'd0, 16'd4096);
    issue(bsb_pkg::FUNC_EVAL, 5'd1, 16'd6000);
    issue(bsb_pkg::FUNC_EVAL, 5'd2, 16'd8192);
    issue(bsb_pkg::FUNC_EVAL, 5'd3, 16'd10000);
    issue(bsb_pkg::FUNC_EVAL, 5'd4, 16'hFFFF);
    issue(bsb_pkg::FUNC_EVAL, 5'd4, 16'hFFFE);
    issue(bsb_pkg::FUNC_EVAL, 5'd31, 16'hFFFF);
    issue(bsb_pkg::FUNC_EVAL, 5'd28, 16'd0);
    issue(bsb_pkg::FUNC_EVAL, 5'd27, 16'd100);
    drain();

    for (int ph = 0; ph < 10; ph++) begin
      set_order(orders[ph]);
      no_idle = (ph == 2);
      load_knots(ph == 4 || ph == 8);
      for (int n = 0; n < 33; n++) begin
        if (!no_idle && $urandom_range(0, 99) < 29) gap($urandom_range(1, 6));
        if ($urandom_range(0, 99) < 6) begin
          issue(bsb_pkg::FUNC_WRITE, 5'($urandom_range(0, 31)),
                16'($urandom_range(0, 65535)));
        end else begin
          if ($urandom_range(0, 99) < 10) idx = $urandom_range(0, 31);
          else idx = $urandom_range(0, 31 - eff_order);
          if (idx + eff_order <= 31 && $urandom_range(0, 99) < 85) begin
            lo = int'(shadow_knots[idx]);
            hi = int'(shadow_knots[idx + eff_order]);
            if (lo > hi) begin
              lo = int'(shadow_knots[idx + eff_order]);
              hi = int'(shadow_knots[idx]);
            end
            issue(bsb_pkg::FUNC_EVAL, idx[4:0], 16'($urandom_range(lo, hi)));
          end else begin
            issue(bsb_pkg::FUNC_EVAL, idx[4:0], 16'($urandom_range(0, 65535)));
          end
        end
      end
      drain();
    end

    repeat (100) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("bspline_basis_eval test passed");
    end else begin
      $display("bspline_basis_eval test failed");
    end
    $finish;
  end

endmodule
